// ----- rtl/hwpf_pkg.sv -----
// ----------------------------------------------------------------------------
// hwpf_pkg: shared definitions for the Haar pansharpening block
// Field widths, register map, queue sizing and the types that travel between
// the front end, the block queue and the fusion back end.
// ----------------------------------------------------------------------------
package hwpf_pkg;

  localparam int PIX_W    = 16;
  localparam int SUM_W    = PIX_W + 2;
  localparam int FUSED_W  = 20;
  localparam int BCOL_W   = 9;
  localparam int BROW_W   = 11;
  localparam int CFG_W    = 11;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Depth of the block queue; a power of two so the pointers wrap naturally.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Register index taken from paddr above the byte offset.
  localparam logic [ADDR_W-3:0] REG_ROW_WIDTH = '0;
  localparam logic [CFG_W-1:0]  ROW_WIDTH_RESET = CFG_W'(1024);

  typedef struct packed {
    logic [PIX_W-1:0]  pan_tl;
    logic [PIX_W-1:0]  pan_tr;
    logic [PIX_W-1:0]  pan_bl;
    logic [PIX_W-1:0]  pan_br;
    logic [SUM_W-1:0]  pan_sum;
    logic [SUM_W-1:0]  ms_sum;
    logic [BCOL_W-1:0] bcol;
    logic [BROW_W-1:0] brow;
  } blk_t;

  typedef struct packed {
    logic valid;
    blk_t blk;
  } q_push_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              not_empty;
  } q_stat_t;

endpackage

// ----- rtl/hwpf_ram.sv -----
// ----------------------------------------------------------------------------
// hwpf_ram: generic single-port RAM
// One write or one read per cycle; read data is registered and holds until
// the next read.
// ----------------------------------------------------------------------------
module hwpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/hwpf_front.sv -----
// ----------------------------------------------------------------------------
// hwpf_front: pixel intake and block assembly
// Tracks row and column, writes even rows to the line store, reads it back on
// odd rows and assembles each completed 2x2 block with its pixel sums.
// ----------------------------------------------------------------------------
module hwpf_front #(
  parameter int MAX_WIDTH  = hwpf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = hwpf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [hwpf_pkg::PIX_W-1:0] pan,
  input  logic [hwpf_pkg::PIX_W-1:0] ms,
  input  logic                       frame_start,
  input  logic [hwpf_pkg::CFG_W-1:0] row_width,
  input  hwpf_pkg::q_stat_t          q_stat,
  output logic                       full,
  output hwpf_pkg::q_push_t          q_push
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int LEN_W = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (LEN_W > hwpf_pkg::CFG_W) ? LEN_W : hwpf_pkg::CFG_W;
  localparam int PW    = hwpf_pkg::PIX_W;
  localparam int SW    = hwpf_pkg::SUM_W;
  localparam int QW    = hwpf_pkg::QCNT_W;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CMP_W-1:0] rw_ext, rw_clamp;
  logic [LEN_W-1:0] len, used, x_len, x_inc;
  logic [ROW_W:0]   y_inc;
  logic [COL_W-1:0] x0, x;
  logic [ROW_W-1:0] y;
  logic             accept, in_used, ram_we, ram_re;
  logic [2*PW-1:0]  rdata;

  logic                          s1_hold_r, s1_hold_nxt, s1_blk_r, s1_blk_nxt;
  logic [PW-1:0]                 s1_pan_r, s1_ms_r;
  logic [hwpf_pkg::BCOL_W-1:0]   s1_bcol_r;
  logic [hwpf_pkg::BROW_W-1:0]   s1_brow_r;
  logic [PW-1:0]                 top_pan_r, top_ms_r, bot_pan_r, bot_ms_r;
  logic [PW-1:0]                 tr_pan, tr_ms;

  // Row length clamped to 2..MAX_WIDTH; the used width drops an odd column.
  always_comb begin
    rw_ext = CMP_W'(row_width);
    if (rw_ext < CMP_W'(2)) begin
      rw_clamp = CMP_W'(2);
    end else if (rw_ext > CMP_W'(MAX_WIDTH)) begin
      rw_clamp = CMP_W'(MAX_WIDTH);
    end else begin
      rw_clamp = rw_ext;
    end
  end

  assign len  = LEN_W'(rw_clamp);
  assign used = len & ~LEN_W'(1);

  assign full = ({1'b0, q_stat.count} + (QW + 1)'(s1_blk_r)) >= (QW + 1)'(hwpf_pkg::QDEPTH);
  assign accept = push & ~full;

  always_comb begin
    x0 = frame_start ? '0 : col_r;
    y  = frame_start ? '0 : row_r;
    // A column left over from a wider row starts a fresh row.
    x  = (LEN_W'(x0) >= len) ? '0 : x0;
    x_len   = LEN_W'(x);
    in_used = x_len < used;
    x_inc   = x_len + LEN_W'(1);
    y_inc   = (ROW_W + 1)'(y) + (ROW_W + 1)'(1);
    if (x_inc >= len) begin
      col_nxt = '0;
      row_nxt = (y_inc >= (ROW_W + 1)'(MAX_HEIGHT)) ? '0 : ROW_W'(y_inc);
    end else begin
      col_nxt = COL_W'(x_inc);
      row_nxt = y;
    end
  end

  assign ram_we      = accept & in_used & ~y[0];
  assign ram_re      = accept & in_used & y[0];
  assign s1_hold_nxt = ram_re & ~x[0];
  assign s1_blk_nxt  = ram_re & x[0];

  hwpf_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (x),
    .wdata ({pan, ms}),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      s1_hold_r <= 1'b0;
      s1_blk_r  <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      s1_hold_r <= s1_hold_nxt;
      s1_blk_r  <= s1_blk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      s1_pan_r  <= pan;
      s1_ms_r   <= ms;
      s1_bcol_r <= hwpf_pkg::BCOL_W'(32'(x) >> 1);
      s1_brow_r <= hwpf_pkg::BROW_W'(32'(y) >> 1);
    end
    // The left column of an odd row brings the top-left stored pair and the
    // bottom-left pixel; both wait here for the right column.
    if (s1_hold_r) begin
      top_pan_r <= rdata[2*PW-1:PW];
      top_ms_r  <= rdata[PW-1:0];
      bot_pan_r <= s1_pan_r;
      bot_ms_r  <= s1_ms_r;
    end
  end

  assign tr_pan = rdata[2*PW-1:PW];
  assign tr_ms  = rdata[PW-1:0];

  always_comb begin
    q_push.valid       = s1_blk_r;
    q_push.blk.pan_tl  = top_pan_r;
    q_push.blk.pan_tr  = tr_pan;
    q_push.blk.pan_bl  = bot_pan_r;
    q_push.blk.pan_br  = s1_pan_r;
    q_push.blk.pan_sum = SW'(top_pan_r) + SW'(tr_pan) + SW'(bot_pan_r) + SW'(s1_pan_r);
    q_push.blk.ms_sum  = SW'(top_ms_r) + SW'(tr_ms) + SW'(bot_ms_r) + SW'(s1_ms_r);
    q_push.blk.bcol    = s1_bcol_r;
    q_push.blk.brow    = s1_brow_r;
  end

endmodule

// ----- rtl/hwpf_queue.sv -----
// ----------------------------------------------------------------------------
// hwpf_queue: block queue between front end and back end
// A short register queue of assembled blocks, so that a stalled result side
// does not stop pixel intake at once.
// ----------------------------------------------------------------------------
module hwpf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  hwpf_pkg::q_push_t q_push,
  input  logic              pop,
  output hwpf_pkg::blk_t    head,
  output hwpf_pkg::q_stat_t q_stat
);

  localparam int PTR_W = hwpf_pkg::QPTR_W;
  localparam int CNT_W = hwpf_pkg::QCNT_W;

  hwpf_pkg::blk_t   entry [hwpf_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign do_pop = pop & (count_r != '0);

  always_comb begin
    count_nxt = count_r;
    if (q_push.valid && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!q_push.valid && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_push.valid) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.valid) begin
      entry[wr_ptr_r] <= q_push.blk;
    end
  end

  assign head             = entry[rd_ptr_r];
  assign q_stat.count     = count_r;
  assign q_stat.not_empty = count_r != '0;

endmodule

// ----- rtl/hwpf_back.sv -----
// ----------------------------------------------------------------------------
// hwpf_back: fusion and result register
// Forms each fused pixel from its block sums and holds the result until the
// consumer takes it.
// ----------------------------------------------------------------------------
module hwpf_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  hwpf_pkg::q_stat_t                    q_stat,
  input  hwpf_pkg::blk_t                       head,
  output logic                                 q_pop,
  input  logic                                 pop,
  output logic                                 empty,
  output logic signed [hwpf_pkg::FUSED_W-1:0]  fused_tl,
  output logic signed [hwpf_pkg::FUSED_W-1:0]  fused_tr,
  output logic signed [hwpf_pkg::FUSED_W-1:0]  fused_bl,
  output logic signed [hwpf_pkg::FUSED_W-1:0]  fused_br,
  output logic [hwpf_pkg::BCOL_W-1:0]          block_column,
  output logic [hwpf_pkg::BROW_W-1:0]          block_row
);

  localparam int FW = hwpf_pkg::FUSED_W;

  // 4*pan - sum(pan block) + sum(ms block), kept modulo 2^20.
  function automatic logic signed [FW-1:0] fuse(
    input logic [hwpf_pkg::PIX_W-1:0] p,
    input logic [hwpf_pkg::SUM_W-1:0] ps,
    input logic [hwpf_pkg::SUM_W-1:0] msum
  );
    logic [FW-1:0] p4;
    p4 = FW'({p, 2'b00});
    return $signed(p4 - FW'(ps) + FW'(msum));
  endfunction

  logic                 out_valid_r, out_valid_nxt, load;
  logic signed [FW-1:0] tl_r, tr_r, bl_r, br_r;
  logic [hwpf_pkg::BCOL_W-1:0] bcol_r;
  logic [hwpf_pkg::BROW_W-1:0] brow_r;

  assign load          = q_stat.not_empty & (~out_valid_r | pop);
  assign out_valid_nxt = load | (out_valid_r & ~pop);
  assign q_pop         = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tl_r   <= fuse(head.pan_tl, head.pan_sum, head.ms_sum);
      tr_r   <= fuse(head.pan_tr, head.pan_sum, head.ms_sum);
      bl_r   <= fuse(head.pan_bl, head.pan_sum, head.ms_sum);
      br_r   <= fuse(head.pan_br, head.pan_sum, head.ms_sum);
      bcol_r <= head.bcol;
      brow_r <= head.brow;
    end
  end

  assign empty        = ~out_valid_r;
  assign fused_tl     = tl_r;
  assign fused_tr     = tr_r;
  assign fused_bl     = bl_r;
  assign fused_br     = br_r;
  assign block_column = bcol_r;
  assign block_row    = brow_r;

endmodule

// ----- rtl/haar_wavelet_pan_fusion.sv -----
// ----------------------------------------------------------------------------
// haar_wavelet_pan_fusion: one-level Haar pansharpening of a pixel stream
//
//   channel   direction  transfer when          payload
//   input     in         push && !full          pan, ms, frame_start
//   result    out        pop && !empty          four fused pixels, block index
//   config    in/out     psel&&penable&&pwrite  row_width at byte address 0
//
// One pixel pair is taken per cycle while full is low; the line store is
// touched at most once per pixel. A block's result passes through the block
// queue into the result register after the transfer of its bottom-right pixel.
// Reset is synchronous and clears counters, pipeline and queue; the line
// store needs no clearing. A stalled result side fills the four-entry block
// queue, after which full is raised until a result is taken.
// ----------------------------------------------------------------------------
module haar_wavelet_pan_fusion #(
  parameter int MAX_WIDTH  = hwpf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = hwpf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic [hwpf_pkg::PIX_W-1:0]          in_pan_pixel,
  input  logic [hwpf_pkg::PIX_W-1:0]          in_ms_pixel,
  input  logic                                in_frame_start,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [hwpf_pkg::FUSED_W-1:0] out_fused_top_left,
  output logic signed [hwpf_pkg::FUSED_W-1:0] out_fused_top_right,
  output logic signed [hwpf_pkg::FUSED_W-1:0] out_fused_bottom_left,
  output logic signed [hwpf_pkg::FUSED_W-1:0] out_fused_bottom_right,
  output logic [hwpf_pkg::BCOL_W-1:0]         out_block_column,
  output logic [hwpf_pkg::BROW_W-1:0]         out_block_row,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hwpf_pkg::ADDR_W-1:0]         paddr,
  input  logic [hwpf_pkg::DATA_W-1:0]         pwdata,
  output logic [hwpf_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  logic [hwpf_pkg::CFG_W-1:0] row_width_r;
  logic                       reg_sel, cfg_wr;
  hwpf_pkg::q_push_t          q_push;
  hwpf_pkg::q_stat_t          q_stat;
  hwpf_pkg::blk_t             q_head;
  logic                       q_pop;

  assign pready  = 1'b1;
  assign reg_sel = paddr[hwpf_pkg::ADDR_W-1:2] == hwpf_pkg::REG_ROW_WIDTH;
  assign cfg_wr  = psel & penable & pwrite & pready & reg_sel;
  assign prdata  = reg_sel ? hwpf_pkg::DATA_W'(row_width_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= hwpf_pkg::ROW_WIDTH_RESET;
    end else if (cfg_wr) begin
      row_width_r <= pwdata[hwpf_pkg::CFG_W-1:0];
    end
  end

  hwpf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .pan         (in_pan_pixel),
    .ms          (in_ms_pixel),
    .frame_start (in_frame_start),
    .row_width   (row_width_r),
    .q_stat      (q_stat),
    .full        (full),
    .q_push      (q_push)
  );

  hwpf_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (q_pop),
    .head   (q_head),
    .q_stat (q_stat)
  );

  hwpf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .head         (q_head),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .fused_tl     (out_fused_top_left),
    .fused_tr     (out_fused_top_right),
    .fused_bl     (out_fused_bottom_left),
    .fused_br     (out_fused_bottom_right),
    .block_column (out_block_column),
    .block_row    (out_block_row)
  );

endmodule

// ----- rtl/hwpf_checker.sv -----
// ----------------------------------------------------------------------------
// hwpf_checker: port-level checks for the pansharpening block
// Watches both queue-style channels of the top level over time.
// ----------------------------------------------------------------------------
module hwpf_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                push,
  input logic                                full,
  input logic                                empty,
  input logic                                pop,
  input logic signed [hwpf_pkg::FUSED_W-1:0] fused_tl,
  input logic signed [hwpf_pkg::FUSED_W-1:0] fused_tr,
  input logic signed [hwpf_pkg::FUSED_W-1:0] fused_bl,
  input logic signed [hwpf_pkg::FUSED_W-1:0] fused_br
);

  // Reset leaves no result waiting and room for input.
  a_reset_state: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("result pending or input blocked after reset");

  // The four fused values of a block sum to a multiple of four, checked on their low two bits.
  a_sum_multiple: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((fused_tl[1:0] + fused_tr[1:0] + fused_bl[1:0] + fused_br[1:0]) == 2'b00))
    else $error("fused block sum is not a multiple of four");

  // Back pressure only grows after an input transfer.
  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full) |-> $past(push && !full))
    else $error("full raised without a preceding input transfer");

  // A waiting result holds until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(fused_tl) && $stable(fused_br)))
    else $error("waiting result changed before transfer");

endmodule

bind haar_wavelet_pan_fusion hwpf_checker u_hwpf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .fused_tl (out_fused_top_left),
  .fused_tr (out_fused_top_right),
  .fused_bl (out_fused_bottom_left),
  .fused_br (out_fused_bottom_right)
);
